/* rtl/core/crs_pkg.sv */
// Package for the comparison rank sort unit: capacity and index widths.
// No dependencies.
package crs_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int VALUE_W   = 32;
   localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

endpackage

/* rtl/core/crs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module crs_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/comparison_rank_sort_unit.sv */
// Top level of the comparison rank sort unit: input collection, rank sweep, sorted output.
// Depends on crs_pkg and crs_ram.
//
// Values stream in, one transfer per cycle, into a value store of MAX_ITEMS entries;
// the transfer with tlast closes the run. Values past capacity are dropped and every
// result of that run carries overflow. For a run of n values each value is read once
// and then compared against all n stored values, one per cycle through the value
// store's single read port. Each value lands at its rank (signed-smaller values plus
// earlier equal values) in a sorted store, which is then read out in ascending signed
// order, one result at a time: the next is read only after the consumer takes the
// current one, and tlast marks the final result. Input is not taken while a run is
// being sorted or emitted.
module comparison_rank_sort_unit
   import crs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // [31:0] value
   input  logic               req_tlast,   // last
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_tdata,   // [31:0] sorted_value
   output logic               rsp_tlast,   // end_of_run
   output logic [0:0]         rsp_tuser    // [0] overflow
);

   localparam logic [2:0] S_COLLECT   = 3'd0;
   localparam logic [2:0] S_LOAD_I    = 3'd1;
   localparam logic [2:0] S_WAIT_I    = 3'd2;
   localparam logic [2:0] S_SCAN      = 3'd3;
   localparam logic [2:0] S_PLACE     = 3'd4;
   localparam logic [2:0] S_EMIT_RD   = 3'd5;
   localparam logic [2:0] S_EMIT_WAIT = 3'd6;
   localparam logic [2:0] S_EMIT_OUT  = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   rank_ff, rank_in;
   logic [VALUE_W-1:0] vi_ff, vi_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_last_ff, out_last_in;
   logic [VALUE_W-1:0] out_data_ff, out_data_in;

   logic               vs_wr_en;
   logic [IDX_W-1:0]   vs_wr_addr;
   logic [IDX_W-1:0]   vs_rd_addr;
   logic [VALUE_W-1:0] vs_rd_data;
   logic               ss_wr_en;
   logic [VALUE_W-1:0] ss_rd_data;

   logic               req_xfer;
   logic               hit;
   logic [CNT_W-1:0]   rank_total;
   logic               j_is_end;
   logic               i_is_end;

   crs_ram #(.DATA_W(VALUE_W), .DEPTH(MAX_ITEMS)) u_value_store (
      .clock   (clock),
      .wr_en   (vs_wr_en),
      .wr_addr (vs_wr_addr),
      .wr_data (req_tdata),
      .rd_addr (vs_rd_addr),
      .rd_data (vs_rd_data)
   );

   crs_ram #(.DATA_W(VALUE_W), .DEPTH(MAX_ITEMS)) u_sorted_store (
      .clock   (clock),
      .wr_en   (ss_wr_en),
      .wr_addr (rank_ff[IDX_W-1:0]),
      .wr_data (vi_ff),
      .rd_addr (i_ff),
      .rd_data (ss_rd_data)
   );

   assign req_tready = (state_ff == S_COLLECT);
   assign req_xfer   = req_tvalid && req_tready;
   assign vs_wr_en   = req_xfer && (count_ff < CNT_W'(MAX_ITEMS));
   assign vs_wr_addr = count_ff[IDX_W-1:0];
   assign ss_wr_en   = (state_ff == S_PLACE);

   assign hit = ($signed(vs_rd_data) < $signed(vi_ff)) ||
                ((j_ff < i_ff) && (vs_rd_data == vi_ff));
   assign rank_total = rank_ff + CNT_W'(hit);
   assign j_is_end   = (CNT_W'(j_ff) + CNT_W'(1)) == count_ff;
   assign i_is_end   = (CNT_W'(i_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      case (state_ff)
         S_WAIT_I: vs_rd_addr = '0;
         S_SCAN:   vs_rd_addr = j_ff + IDX_W'(1);
         default:  vs_rd_addr = i_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rank_in      = rank_ff;
      vi_in        = vi_ff;
      out_valid_in = out_valid_ff;
      out_last_in  = out_last_ff;
      out_data_in  = out_data_ff;
      case (state_ff)
         S_COLLECT: begin
            if (req_xfer) begin
               if (vs_wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  i_in     = '0;
                  state_in = S_LOAD_I;
               end
            end
         end
         S_LOAD_I: begin
            state_in = S_WAIT_I;
         end
         S_WAIT_I: begin
            vi_in    = vs_rd_data;
            j_in     = '0;
            rank_in  = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            rank_in = rank_total;
            j_in    = j_ff + IDX_W'(1);
            if (j_is_end) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            if (i_is_end) begin
               i_in     = '0;
               state_in = S_EMIT_RD;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = S_LOAD_I;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            out_data_in  = ss_rd_data;
            out_last_in  = i_is_end;
            out_valid_in = 1'b1;
            state_in     = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (rsp_tready) begin
               out_valid_in = 1'b0;
               if (out_last_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_COLLECT;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         rank_ff      <= '0;
         out_valid_ff <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rank_ff      <= rank_in;
         out_valid_ff <= out_valid_in;
         out_last_ff  <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      vi_ff       <= vi_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = dropped_ff;

endmodule
